// ----- hdl/ubre_pkg.sv -----
// ----------------------------------------------------------------------------
// ubre_pkg
// Shared types and constants of the 8-N-1 receiver with frame echo.
// ----------------------------------------------------------------------------
package ubre_pkg;

  localparam int unsigned TickW  = 16;
  localparam int unsigned DataW  = 8;
  localparam int unsigned PhaseW = 4;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [PhaseW-1:0] RxIdle   = 4'd9;
  localparam logic [PhaseW-1:0] TxStop   = 4'd9;
  localparam logic [PhaseW-1:0] TxPastStop = 4'd10;

  localparam logic [TickW-1:0] TxBitReset   = 16'd100;
  localparam logic [TickW-1:0] RxBitReset   = 16'd108;
  localparam logic [TickW-1:0] RxFirstReset = 16'd108;

  localparam int unsigned QDepth = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TX_BIT   = 2'd0,
    CFG_RX_BIT   = 2'd1,
    CFG_RX_FIRST = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] tx_bit_ticks;
    logic [TickW-1:0] rx_bit_ticks;
    logic [TickW-1:0] rx_first_ticks;
  } cfg_t;

  typedef struct packed {
    logic             store;
    logic [DataW-1:0] value;
  } word_t;

  function automatic logic [TickW-1:0] ticks_of(input logic [TickW-1:0] v);
    ticks_of = (v == '0) ? TickW'(1) : v;
  endfunction

endpackage

// ----- hdl/uart_block_receive_echo_top.sv -----
// ----------------------------------------------------------------------------
// uart_block_receive_echo_top
// Timed 8-N-1 receiver that stores bytes in a frame buffer and echoes the
// full frame on the transmit line.
//
//   port group   direction  handshake                 payload
//   in           to block   in_valid_i / in_stall_o   rx_level_i
//   out          from block out_valid_o / out_stall_i tx_level_o, byte_done_o,
//                                                      byte_value_o
//   cfg          to block   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One tick word is taken per cycle while in_stall_o is low; its result word
// passes the receive front, then the two-entry queue, then the echo back and
// is registered in the output register of the echo back. in_stall_o rises
// only when the queue is full. Reset clears all timing and count state;
// there is no clearing pass.
// ----------------------------------------------------------------------------
module uart_block_receive_echo_top #(
  parameter int unsigned FRAME_BYTES = 11
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           rx_level_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           tx_level_o,
  output logic                           byte_done_o,
  output logic [ubre_pkg::DataW-1:0]     byte_value_o,
  input  logic                           cfg_we_i,
  input  logic [ubre_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ubre_pkg::TickW-1:0]     cfg_data_i
);

  ubre_pkg::cfg_t  cfg_q;
  ubre_pkg::word_t front_word;
  ubre_pkg::word_t back_word;
  logic            q_full;
  logic            q_avail;
  logic            q_pop;
  logic            accept;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tx_bit_ticks   <= ubre_pkg::TxBitReset;
      cfg_q.rx_bit_ticks   <= ubre_pkg::RxBitReset;
      cfg_q.rx_first_ticks <= ubre_pkg::RxFirstReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ubre_pkg::CFG_TX_BIT:   cfg_q.tx_bit_ticks   <= cfg_data_i;
        ubre_pkg::CFG_RX_BIT:   cfg_q.rx_bit_ticks   <= cfg_data_i;
        ubre_pkg::CFG_RX_FIRST: cfg_q.rx_first_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ubre_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (accept),
    .rx_level_i (rx_level_i),
    .word_o     (front_word)
  );

  ubre_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .word_i  (front_word),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .word_o  (back_word)
  );

  ubre_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .avail_i      (q_avail),
    .word_i       (back_word),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .tx_level_o   (tx_level_o),
    .byte_done_o  (byte_done_o),
    .byte_value_o (byte_value_o)
  );

endmodule

// ----- hdl/ubre_front.sv -----
// ----------------------------------------------------------------------------
// ubre_front
// Receive timing: start edge detection, data sampling and byte completion.
// ----------------------------------------------------------------------------
module ubre_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ubre_pkg::cfg_t                cfg_i,
  input  logic                          accept_i,
  input  logic                          rx_level_i,
  output ubre_pkg::word_t               word_o
);

  logic [ubre_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [ubre_pkg::TickW-1:0]  timer_q, timer_d;
  logic                        prev_q, prev_d;
  logic [ubre_pkg::DataW-1:0]  shift_q, shift_d;
  logic [ubre_pkg::TickW-1:0]  timer_m;
  logic [ubre_pkg::PhaseW-1:0] phase_n;

  always_comb begin
    phase_d      = phase_q;
    timer_d      = timer_q;
    shift_d      = shift_q;
    prev_d       = rx_level_i;
    word_o.store = 1'b0;
    timer_m      = timer_q - ubre_pkg::TickW'(1);
    phase_n      = phase_q + ubre_pkg::PhaseW'(1);
    if (phase_q == ubre_pkg::RxIdle) begin
      if (prev_q && !rx_level_i) begin
        phase_d = '0;
        timer_d = ubre_pkg::ticks_of(cfg_i.rx_first_ticks);
      end
    end else begin
      timer_d = timer_m;
      if (timer_m == '0) begin
        phase_d = phase_n;
        if (phase_n == ubre_pkg::RxIdle) begin
          word_o.store = 1'b1;
        end else begin
          shift_d[3'(phase_n - ubre_pkg::PhaseW'(1))] = rx_level_i;
          timer_d = ubre_pkg::ticks_of(cfg_i.rx_bit_ticks);
        end
      end
    end
    word_o.value = shift_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ubre_pkg::RxIdle;
      timer_q <= '0;
      prev_q  <= 1'b1;
      shift_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      prev_q  <= prev_d;
      shift_q <= shift_d;
    end
  end

endmodule

// ----- hdl/ubre_queue.sv -----
// ----------------------------------------------------------------------------
// ubre_queue
// Short word queue between the receive front and the echo back.
// ----------------------------------------------------------------------------
module ubre_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ubre_pkg::word_t word_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            avail_o,
  output ubre_pkg::word_t word_o
);

  localparam int unsigned PtrW = $clog2(ubre_pkg::QDepth);
  localparam int unsigned CntW = $clog2(ubre_pkg::QDepth + 1);

  ubre_pkg::word_t mem_q [ubre_pkg::QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(ubre_pkg::QDepth));
  assign avail_o = (cnt_q != '0);
  assign word_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ((wr_q == PtrW'(ubre_pkg::QDepth - 1)) ? '0 : wr_q + PtrW'(1)) : wr_q;
    rd_d  = pop_i  ? ((rd_q == PtrW'(ubre_pkg::QDepth - 1)) ? '0 : rd_q + PtrW'(1)) : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- hdl/ubre_back.sv -----
// ----------------------------------------------------------------------------
// ubre_back
// Frame buffer, echo start and transmit bit timing, with the output register.
// ----------------------------------------------------------------------------
module ubre_back #(
  parameter int unsigned FRAME_BYTES = 11
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ubre_pkg::cfg_t               cfg_i,
  input  logic                         avail_i,
  input  ubre_pkg::word_t              word_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         tx_level_o,
  output logic                         byte_done_o,
  output logic [ubre_pkg::DataW-1:0]   byte_value_o
);

  localparam int unsigned CntW = $clog2(FRAME_BYTES + 1);
  localparam int unsigned IdxW = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [CntW-1:0] Full = CntW'(FRAME_BYTES);

  logic [ubre_pkg::DataW-1:0]  buf_q [FRAME_BYTES];
  logic [CntW-1:0]             count_q, count_d;
  logic                        busy_q, busy_d;
  logic [CntW-1:0]             byte_q, byte_d;
  logic [ubre_pkg::PhaseW-1:0] bit_q, bit_d;
  logic [ubre_pkg::TickW-1:0]  timer_q, timer_d;
  logic [ubre_pkg::DataW-1:0]  shift_q, shift_d;
  logic                        out_valid_q, out_valid_d;
  logic                        txl_q, txl_d;
  logic                        done_q;
  logic [ubre_pkg::DataW-1:0]  value_q, value_d;

  logic                        adv;
  logic                        wr;
  logic                        echo;
  logic [CntW-1:0]             count_a;
  logic [CntW-1:0]             byte_n;
  logic [ubre_pkg::PhaseW-1:0] bit_n;
  logic [ubre_pkg::TickW-1:0]  timer_m;
  logic [IdxW-1:0]             rd_addr;
  logic [ubre_pkg::DataW-1:0]  rd_data;

  assign adv   = avail_i && (!out_valid_q || !out_stall_i);
  assign pop_o = adv;

  always_comb begin
    wr      = word_i.store && (count_q < Full);
    count_a = wr ? count_q + CntW'(1) : count_q;
    echo    = !busy_q && (count_a >= Full);
    byte_n  = byte_q + CntW'(1);
    rd_addr = echo ? '0 : byte_n[IdxW-1:0];
    rd_data = (wr && (count_q[IdxW-1:0] == rd_addr)) ? word_i.value : buf_q[rd_addr];

    count_d = echo ? '0 : count_a;
    busy_d  = busy_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    timer_d = timer_q;
    shift_d = shift_q;
    if (echo) begin
      busy_d  = 1'b1;
      byte_d  = '0;
      bit_d   = '0;
      timer_d = ubre_pkg::ticks_of(cfg_i.tx_bit_ticks);
      shift_d = rd_data;
    end

    txl_d   = 1'b1;
    timer_m = timer_d - ubre_pkg::TickW'(1);
    bit_n   = bit_d + ubre_pkg::PhaseW'(1);
    if (busy_d) begin
      if (bit_d == '0) begin
        txl_d = 1'b0;
      end else if (bit_d >= ubre_pkg::TxStop) begin
        txl_d = 1'b1;
      end else begin
        txl_d = shift_d[0];
      end
      timer_d = timer_m;
      if (timer_m == '0) begin
        if (bit_d != '0 && bit_d < ubre_pkg::TxStop) begin
          shift_d = shift_d >> 1;
        end
        bit_d   = bit_n;
        timer_d = ubre_pkg::ticks_of(cfg_i.tx_bit_ticks);
        if (bit_n == ubre_pkg::TxPastStop) begin
          bit_d  = '0;
          byte_d = byte_n;
          if (byte_n >= Full) begin
            busy_d  = 1'b0;
            byte_d  = '0;
            timer_d = '0;
          end else begin
            shift_d = rd_data;
          end
        end
      end
    end

    value_d = wr ? word_i.value : '0;

    if (adv) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && wr) begin
      buf_q[count_q[IdxW-1:0]] <= word_i.value;
    end
    if (adv) begin
      txl_q   <= txl_d;
      value_q <= value_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      busy_q      <= 1'b0;
      byte_q      <= '0;
      bit_q       <= '0;
      timer_q     <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (adv) begin
        count_q <= count_d;
        busy_q  <= busy_d;
        byte_q  <= byte_d;
        bit_q   <= bit_d;
        timer_q <= timer_d;
        shift_q <= shift_d;
        done_q  <= wr;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tx_level_o   = txl_q;
  assign byte_done_o  = done_q;
  assign byte_value_o = value_q;

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 8-N-1 receiver with frame echo. Line ticks are
// fed one word per handshake, with random sender gaps and receiver stalls.
// The bench keeps its own cycle model of the receiver, frame buffer and echo
// transmitter, and checks every result word against it field by field.
// Reset settings and line toggles inside a frame come first, then zero and
// full-scale tick counts, then random runs of well-formed frames mixed with
// line noise under small random bit timings.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FrameBytes = 11;

  typedef struct packed {
    logic                      tx_level;
    logic                      byte_done;
    logic [ubre_pkg::DataW-1:0] byte_value;
  } line_word_t;

  logic                          clk_i      = 1'b0;
  logic                          rst_ni     = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          rx_level_i = 1'b1;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          tx_level_o;
  logic                          byte_done_o;
  logic [ubre_pkg::DataW-1:0]    byte_value_o;
  logic                          cfg_we_i   = 1'b0;
  logic [ubre_pkg::CfgIdxW-1:0]  cfg_idx_i  = '0;
  logic [ubre_pkg::TickW-1:0]    cfg_data_i = '0;

  uart_block_receive_echo_top #(
    .FRAME_BYTES(FrameBytes)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_level_i  (rx_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_level_o  (tx_level_o),
    .byte_done_o (byte_done_o),
    .byte_value_o(byte_value_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ubre_pkg::cfg_t              regs_q;
  logic [ubre_pkg::PhaseW-1:0] line_phase;
  logic [ubre_pkg::TickW-1:0]  line_timer;
  logic                        line_last;
  logic [ubre_pkg::DataW-1:0]  line_shift;
  logic [ubre_pkg::DataW-1:0]  frame_mem [FrameBytes];
  logic [3:0]                  held_cnt;
  logic                        echo_busy;
  logic [3:0]                  echo_byte;
  logic [ubre_pkg::PhaseW-1:0] echo_bit;
  logic [ubre_pkg::TickW-1:0]  echo_timer;
  logic [ubre_pkg::DataW-1:0]  echo_shift;

  logic        tick_q[$];
  line_word_t  line_word_q[$];

  int unsigned fail_cnt     = 0;
  int unsigned ticks_pushed = 0;
  int unsigned words_checked = 0;
  int unsigned stored_cnt   = 0;
  int unsigned dropped_cnt  = 0;
  int unsigned echo_cnt     = 0;
  int unsigned send_gap     = 0;
  int unsigned stall_left   = 0;
  bit          send_quiet   = 1'b0;
  bit          recv_quiet   = 1'b0;

  function automatic logic [ubre_pkg::TickW-1:0] period_of(
    input logic [ubre_pkg::TickW-1:0] v);
    return (v == '0) ? ubre_pkg::TickW'(1) : v;
  endfunction

  task automatic reset_line_model();
    regs_q.tx_bit_ticks   = ubre_pkg::TxBitReset;
    regs_q.rx_bit_ticks   = ubre_pkg::RxBitReset;
    regs_q.rx_first_ticks = ubre_pkg::RxFirstReset;
    line_phase = ubre_pkg::RxIdle;
    line_timer = '0;
    line_last  = 1'b1;
    line_shift = '0;
    foreach (frame_mem[i]) frame_mem[i] = '0;
    held_cnt   = '0;
    echo_busy  = 1'b0;
    echo_byte  = '0;
    echo_bit   = '0;
    echo_timer = '0;
    echo_shift = '0;
  endtask

  function automatic line_word_t predict_line_word(input logic level);
    line_word_t w;
    w = '{tx_level: 1'b1, byte_done: 1'b0, byte_value: '0};

    if (line_phase >= ubre_pkg::RxIdle) begin
      line_phase = ubre_pkg::RxIdle;
      if (line_last && !level) begin
        line_phase = '0;
        line_timer = period_of(regs_q.rx_first_ticks);
      end
    end else begin
      line_timer = line_timer - 1'b1;
      if (line_timer == '0) begin
        line_phase = line_phase + 1'b1;
        if (line_phase == ubre_pkg::RxIdle) begin
          if (held_cnt < FrameBytes) begin
            frame_mem[held_cnt] = line_shift;
            held_cnt = held_cnt + 1'b1;
            w.byte_done  = 1'b1;
            w.byte_value = line_shift;
            stored_cnt++;
          end else begin
            dropped_cnt++;
          end
        end else begin
          line_shift[line_phase - 1'b1] = level;
          line_timer = period_of(regs_q.rx_bit_ticks);
        end
      end
    end
    line_last = level;

    if (!echo_busy && held_cnt >= FrameBytes) begin
      held_cnt   = '0;
      echo_busy  = 1'b1;
      echo_byte  = '0;
      echo_bit   = '0;
      echo_timer = period_of(regs_q.tx_bit_ticks);
      echo_shift = frame_mem[0];
      echo_cnt++;
    end

    if (echo_busy) begin
      if (echo_bit == '0) w.tx_level = 1'b0;
      else if (echo_bit >= ubre_pkg::TxStop) w.tx_level = 1'b1;
      else w.tx_level = echo_shift[0];

      echo_timer = echo_timer - 1'b1;
      if (echo_timer == '0) begin
        if (echo_bit >= 1 && echo_bit < ubre_pkg::TxStop) echo_shift = echo_shift >> 1;
        echo_bit   = echo_bit + 1'b1;
        echo_timer = period_of(regs_q.tx_bit_ticks);
        if (echo_bit >= ubre_pkg::TxPastStop) begin
          echo_bit  = '0;
          echo_byte = echo_byte + 1'b1;
          if (echo_byte >= FrameBytes) begin
            echo_busy  = 1'b0;
            echo_byte  = '0;
            echo_timer = '0;
          end else begin
            echo_shift = frame_mem[echo_byte];
          end
        end
      end
    end
    return w;
  endfunction

  always @(posedge clk_i) begin
    logic nxt_valid;
    logic nxt_level;
    nxt_valid = in_valid_i;
    nxt_level = rx_level_i;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        line_word_q.push_back(predict_line_word(rx_level_i));
        nxt_valid = 1'b0;
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
        send_gap = send_quiet ? 0 : $urandom_range(0, 5);
      end
      if (!nxt_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (tick_q.size() != 0) begin
          nxt_valid = 1'b1;
          nxt_level = tick_q.pop_front();
        end
      end
    end
    in_valid_i <= nxt_valid;
    rx_level_i <= nxt_level;
  end

  always @(posedge clk_i) begin
    line_word_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        words_checked++;
        if (line_word_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_cnt++;
        end else begin
          want = line_word_q.pop_front();
          if (tx_level_o !== want.tx_level) begin
            $error("tx_level: expected %0b, got %0b", want.tx_level, tx_level_o);
            fail_cnt++;
          end
          if (byte_done_o !== want.byte_done) begin
            $error("byte_done: expected %0b, got %0b", want.byte_done, byte_done_o);
            fail_cnt++;
          end
          if (byte_value_o !== want.byte_value) begin
            $error("byte_value: expected %0h, got %0h", want.byte_value, byte_value_o);
            fail_cnt++;
          end
        end
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
        stall_left = recv_quiet ? 0 : $urandom_range(0, 5);
      end else if (stall_left != 0) begin
        stall_left--;
      end
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic add_tick(input logic level);
    tick_q.push_back(level);
    ticks_pushed++;
  endtask

  task automatic add_frame(input logic [ubre_pkg::DataW-1:0] data);
    int unsigned j;
    repeat (period_of(regs_q.rx_first_ticks)) add_tick(1'b0);
    for (j = 0; j < ubre_pkg::DataW; j++) begin
      repeat (period_of(regs_q.rx_bit_ticks)) add_tick(data[j]);
    end
    add_tick(1'b1);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid_i || line_word_q.size() != 0);
    repeat (3) @(negedge clk_i);
  endtask

  // hold the line high until the receiver is back to idle
  task automatic settle_receiver();
    int unsigned left;
    wait_drained();
    left = 0;
    if (line_phase < ubre_pkg::RxIdle)
      left = line_timer + (ubre_pkg::RxIdle - 1 - line_phase) * period_of(regs_q.rx_bit_ticks);
    repeat (left + 1) add_tick(1'b1);
  endtask

  task automatic program_reg(input ubre_pkg::cfg_idx_e idx,
                             input logic [ubre_pkg::TickW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      ubre_pkg::CFG_TX_BIT:   regs_q.tx_bit_ticks   = value;
      ubre_pkg::CFG_RX_BIT:   regs_q.rx_bit_ticks   = value;
      ubre_pkg::CFG_RX_FIRST: regs_q.rx_first_ticks = value;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned base;
    reset_line_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // toggle the line inside a frame at reset timing
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b1);
    add_tick(1'b1);
    add_tick(1'b0);
    add_tick(1'b1);
    settle_receiver();
    wait_drained();

    program_reg(ubre_pkg::CFG_TX_BIT, '0);
    program_reg(ubre_pkg::CFG_RX_BIT, '0);
    program_reg(ubre_pkg::CFG_RX_FIRST, '0);
    add_frame(8'h00);
    add_frame(8'hFF);
    add_frame(8'h01);
    add_frame(8'h80);
    wait_drained();

    // full-scale transmit count; no echo falls due while it is set
    program_reg(ubre_pkg::CFG_TX_BIT, '1);
    program_reg(ubre_pkg::CFG_RX_FIRST, ubre_pkg::TickW'(1));
    program_reg(ubre_pkg::CFG_RX_BIT, ubre_pkg::TickW'(1));
    add_frame(ubre_pkg::DataW'($urandom_range(0, 255)));
    settle_receiver();

    base = ticks_pushed;
    while (ticks_pushed - base < 300) begin
      wait_drained();
      program_reg(ubre_pkg::CFG_TX_BIT, ubre_pkg::TickW'($urandom_range(0, 4)));
      program_reg(ubre_pkg::CFG_RX_BIT, ubre_pkg::TickW'($urandom_range(0, 2)));
      program_reg(ubre_pkg::CFG_RX_FIRST, ubre_pkg::TickW'($urandom_range(0, 3)));
      repeat ($urandom_range(4, 14)) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 8)) add_tick(1'($urandom_range(0, 1)));
        end else begin
          add_frame(ubre_pkg::DataW'($urandom_range(0, 255)));
          repeat ($urandom_range(0, 2)) add_tick(1'b1);
        end
      end
      settle_receiver();
    end

    wait_drained();
    $display("checked %0d tick words; %0d bytes stored, %0d dropped on a full buffer",
             words_checked, stored_cnt, dropped_cnt);
    $display("%0d frame echoes started across zero, small and full-scale tick counts",
             echo_cnt);
    if (fail_cnt == 0 && line_word_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
